[sv/swia_pkg.sv]
// Shared constants for the signed wide integer ALU.
`default_nettype none

package swia_pkg;

   localparam int HALF_BITS         = 64;
   localparam int FULL_BITS         = 2 * HALF_BITS;
   localparam int OP_BITS           = 3;
   localparam int WORD_BITS_DEFAULT = 128;

   localparam logic [OP_BITS-1:0] OP_ADD = 3'd0;
   localparam logic [OP_BITS-1:0] OP_SUB = 3'd1;
   localparam logic [OP_BITS-1:0] OP_MUL = 3'd2;
   localparam logic [OP_BITS-1:0] OP_DIV = 3'd3;
   localparam logic [OP_BITS-1:0] OP_REM = 3'd4;

endpackage

`default_nettype wire

[sv/swia_addsub.sv]
// Shared adder/subtractor with carry out for the wide ALU.
`default_nettype none

module swia_addsub import swia_pkg::*; #(
   parameter int WIDTH = WORD_BITS_DEFAULT
) (
   input  wire logic [WIDTH-1:0] x,
   input  wire logic [WIDTH-1:0] y,
   input  wire logic             sub,
   output logic      [WIDTH-1:0] sum,
   output logic                  carry
);

   logic [WIDTH-1:0] y_eff;
   logic [WIDTH:0]   total;

   assign y_eff = sub ? ~y : y;
   assign total = {1'b0, x} + {1'b0, y_eff} + (WIDTH+1)'(sub);
   assign sum   = total[WIDTH-1:0];
   assign carry = total[WIDTH];

endmodule

`default_nettype wire

[sv/signed_wide_integer_alu.sv]
// Top level of the signed wide integer ALU: sequencer, operand registers, result slot.
`default_nettype none

// Add and subtract form the result in the fix state on the shared adder; multiply,
// divide and remainder take the operand magnitudes (states NEGA and NEGB), take a
// step per bit of the word on the single shared WORD_BITS-wide adder (shift-add or
// restoring shift-subtract), and fix the sign. Divide or remainder by zero goes
// straight to the fix state and answers zero with rsp_divide_by_zero set. The fix
// state waits for a free result slot. Only the low WORD_BITS bits of each operand count; the result is
// sign-extended to 128 bits. One transaction is in flight at a time; a new request
// is taken while the previous result waits on the response side.

module signed_wide_integer_alu import swia_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [OP_BITS-1:0]    req_type,
   input  wire logic [HALF_BITS-1:0]  req_operand_a_lo,
   input  wire logic signed [HALF_BITS-1:0] req_operand_a_hi,
   input  wire logic [HALF_BITS-1:0]  req_operand_b_lo,
   input  wire logic signed [HALF_BITS-1:0] req_operand_b_hi,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [HALF_BITS-1:0]       rsp_result_lo,
   output logic signed [HALF_BITS-1:0] rsp_result_hi,
   output logic                       rsp_divide_by_zero
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_NEGA = 3'd1;
   localparam logic [2:0] ST_NEGB = 3'd2;
   localparam logic [2:0] ST_LOOP = 3'd3;
   localparam logic [2:0] ST_FIX  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [OP_BITS-1:0]   op_ff, op_in;
   logic                 sa_ff, sa_in;
   logic                 sb_ff, sb_in;
   logic                 dz_ff, dz_in;
   logic [WORD_BITS-1:0] xa_ff, xa_in;
   logic [WORD_BITS-1:0] xb_ff, xb_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] res_ff, res_in;
   logic                 rdz_ff, rdz_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [FULL_BITS-1:0] a_full, b_full, res_ext;
   logic [WORD_BITS-1:0] a_trim, b_trim;
   logic [WORD_BITS-1:0] u_x, u_y, u_sum;
   logic                 u_sub, u_carry;
   logic                 accept, slot_free, is_div, ge;
   logic [WORD_BITS-1:0] rem_sh;

   assign a_full = {req_operand_a_hi, req_operand_a_lo};
   assign b_full = {req_operand_b_hi, req_operand_b_lo};
   assign a_trim = a_full[WORD_BITS-1:0];
   assign b_trim = b_full[WORD_BITS-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_div    = (req_type == OP_DIV) || (req_type == OP_REM);

   assign rem_sh = {acc_ff[WORD_BITS-2:0], xa_ff[WORD_BITS-1]};
   assign ge     = acc_ff[WORD_BITS-1] || u_carry;

   swia_addsub #(.WIDTH(WORD_BITS)) u_addsub (
      .x     (u_x),
      .y     (u_y),
      .sub   (u_sub),
      .sum   (u_sum),
      .carry (u_carry)
   );

   // Shared unit operand selection.
   always_comb begin
      u_x   = '0;
      u_y   = '0;
      u_sub = 1'b1;
      unique case (state_ff)
         ST_NEGA: u_y = xa_ff;
         ST_NEGB: u_y = xb_ff;
         ST_LOOP: begin
            if (op_ff == OP_MUL) begin
               u_x   = acc_ff;
               u_y   = xb_ff[0] ? xa_ff : '0;
               u_sub = 1'b0;
            end else begin
               u_x = rem_sh;
               u_y = xb_ff;
            end
         end
         ST_FIX: begin
            case (op_ff)
               OP_ADD: begin
                  u_x   = xa_ff;
                  u_y   = xb_ff;
                  u_sub = 1'b0;
               end
               OP_SUB: begin
                  u_x = xa_ff;
                  u_y = xb_ff;
               end
               OP_DIV:  u_y = xa_ff;
               default: u_y = acc_ff;
            endcase
         end
         default: ;
      endcase
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      dz_in        = dz_ff;
      xa_in        = xa_ff;
      xb_in        = xb_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rdz_in       = rdz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_type;
               xa_in  = a_trim;
               xb_in  = b_trim;
               sa_in  = a_trim[WORD_BITS-1];
               sb_in  = b_trim[WORD_BITS-1];
               dz_in  = is_div && (b_trim == '0);
               acc_in = '0;
               cnt_in = '0;
               if ((req_type == OP_MUL || is_div) && !(is_div && b_trim == '0)) begin
                  state_in = ST_NEGA;
               end else begin
                  state_in = ST_FIX;
               end
            end
         end
         ST_NEGA: begin
            if (sa_ff) begin
               xa_in = u_sum;
            end
            state_in = ST_NEGB;
         end
         ST_NEGB: begin
            if (sb_ff) begin
               xb_in = u_sum;
            end
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (op_ff == OP_MUL) begin
               acc_in = u_sum;
               xa_in  = {xa_ff[WORD_BITS-2:0], 1'b0};
               xb_in  = {1'b0, xb_ff[WORD_BITS-1:1]};
            end else begin
               acc_in = ge ? u_sum : rem_sh;
               xa_in  = {xa_ff[WORD_BITS-2:0], ge};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (slot_free) begin
               rdz_in       = dz_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (dz_ff) begin
                  res_in = '0;
               end else begin
                  case (op_ff) inside
                     OP_ADD, OP_SUB: res_in = u_sum;
                     OP_MUL:  res_in = (sa_ff ^ sb_ff) ? u_sum : acc_ff;
                     OP_DIV:  res_in = (sa_ff ^ sb_ff) ? u_sum : xa_ff;
                     OP_REM:  res_in = sa_ff ? u_sum : acc_ff;
                     default: res_in = '0;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      dz_ff  <= dz_in;
      xa_ff  <= xa_in;
      xb_ff  <= xb_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      rdz_ff <= rdz_in;
   end

   assign res_ext            = FULL_BITS'(signed'(res_ff));
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_lo      = res_ext[HALF_BITS-1:0];
   assign rsp_result_hi      = res_ext[FULL_BITS-1:HALF_BITS];
   assign rsp_divide_by_zero = rdz_ff;

endmodule

`default_nettype wire
